/* sv/r4la_pkg.sv */
// Shared constants and types for the radius-4 line automaton step block.
`timescale 1ns / 1ps
`default_nettype none

package r4la_pkg;

  localparam int unsigned DEF_RADIUS = 4;
  localparam int unsigned MASK_BITS  = 9;
  localparam int unsigned CFG_IDX_W  = 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DIE_MASK   = 1'b0,
    CFG_BIRTH_MASK = 1'b1
  } cfg_idx_e;

  // control broadcast along the cell chain
  typedef struct packed {
    logic step;
    logic clr;
  } cell_ctrl_t;

  typedef struct packed {
    logic next;
    logic changed;
  } rule_res_t;

endpackage

`default_nettype wire

/* sv/r4la_cell.sv */
// One window cell: holds a single past cell state and hands it to its right neighbour.
`timescale 1ns / 1ps
`default_nettype none

module r4la_cell (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  r4la_pkg::cell_ctrl_t ctrl_i,
  input  wire                  left_i,
  output logic                 tap_o
);

  logic state_q;
  logic state_d;

  always_comb begin
    state_d = ctrl_i.step ? left_i : state_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= 1'b0;
    end else begin
      state_q <= state_d;
    end
  end

  // a first mark empties the window for the current step
  assign tap_o = ctrl_i.clr ? 1'b0 : state_q;

endmodule

`default_nettype wire

/* sv/r4la_rule.sv */
// Neighbour count and die/birth rule lookup for the window centre.
`timescale 1ns / 1ps
`default_nettype none

module r4la_rule #(
  parameter int unsigned RADIUS = r4la_pkg::DEF_RADIUS
) (
  input  wire [2*RADIUS:0]                die_win_i,
  input  wire [r4la_pkg::MASK_BITS-1:0]   die_mask_i,
  input  wire [r4la_pkg::MASK_BITS-1:0]   birth_mask_i,
  output r4la_pkg::rule_res_t             res_o
);

  localparam int unsigned CNT_W = $clog2(2 * RADIUS + 1);

  logic [CNT_W-1:0] count;
  logic             centre;
  logic             die_bit;
  logic             birth_bit;

  always_comb begin
    count     = '0;
    die_bit   = 1'b0;
    birth_bit = 1'b0;
    centre    = die_win_i[RADIUS];
    for (int i = 0; i <= 2 * RADIUS; i++) begin
      if (i != RADIUS) begin
        count = count + CNT_W'(die_win_i[i]);
      end
    end
    // counts beyond the mask width read as zero
    for (int j = 0; j < r4la_pkg::MASK_BITS; j++) begin
      if (int'(count) == j) begin
        die_bit   = die_mask_i[j];
        birth_bit = birth_mask_i[j];
      end
    end
    res_o.next    = centre ? ~die_bit : birth_bit;
    res_o.changed = res_o.next ^ centre;
  end

endmodule

`default_nettype wire

/* sv/radius4_line_automaton_step.sv */
// Top level: one generation of a radius-R outer-totalistic line automaton.
// Takes one item per cycle while in_ready_o is high; each item shifts one cell
// into a chain of 2*RADIUS window cells and yields the new state of the cell
// RADIUS places back, registered in the output register. An item with the last
// mark is followed by 2*RADIUS flush steps that shift dead cells through the
// chain, during which in_ready_o is low, so a generation of N cells gives
// N + 2*RADIUS results, the last one flagged by run_end_o.
`timescale 1ns / 1ps
`default_nettype none

module radius4_line_automaton_step #(
  parameter int unsigned RADIUS = r4la_pkg::DEF_RADIUS
) (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  input  wire                                 cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire  [r4la_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  wire  [r4la_pkg::MASK_BITS-1:0]      cfg_data_i,
  input  wire                                 in_valid_i,
  output logic                                in_ready_o,
  input  wire                                 cell_in_i,
  input  wire                                 first_cell_i,
  input  wire                                 last_cell_i,
  output logic                                out_valid_o,
  input  wire                                 out_ready_i,
  output logic                                cell_out_o,
  output logic                                cell_changed_o,
  output logic                                any_change_o,
  output logic                                run_end_o
);

  localparam int unsigned WIN   = 2 * RADIUS;
  localparam int unsigned FCNT_W = $clog2(WIN + 1);

  logic [r4la_pkg::MASK_BITS-1:0] die_mask_q, birth_mask_q;
  logic [FCNT_W-1:0]              flush_cnt_q, flush_cnt_d;
  logic                           seen_q, seen_d;
  logic                           out_valid_q, out_valid_d;
  logic                           cell_out_q, changed_q, any_q, end_q;

  logic                 slot_free, flushing, accept, step;
  r4la_pkg::cell_ctrl_t ctrl;
  logic [WIN-1:0]       tap;
  logic [WIN:0]         win;
  r4la_pkg::rule_res_t  res;
  logic                 end_now;

  assign cfg_ready_o = 1'b1;
  assign slot_free   = !out_valid_q || out_ready_i;
  assign flushing    = flush_cnt_q != '0;
  assign in_ready_o  = slot_free && !flushing;
  assign accept      = in_valid_i && in_ready_o;
  assign step        = accept || (flushing && slot_free);
  assign ctrl.step   = step;
  assign ctrl.clr    = accept && first_cell_i;
  assign win[0]      = accept ? cell_in_i : 1'b0;
  assign win[WIN:1]  = tap;

  for (genvar g = 0; g < WIN; g++) begin : g_cell
    r4la_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctrl_i (ctrl),
      .left_i (win[g]),
      .tap_o  (tap[g])
    );
  end

  r4la_rule #(
    .RADIUS (RADIUS)
  ) u_rule (
    .die_win_i    (win),
    .die_mask_i   (die_mask_q),
    .birth_mask_i (birth_mask_q),
    .res_o        (res)
  );

  always_comb begin
    end_now     = flushing && (flush_cnt_q == FCNT_W'(1));
    flush_cnt_d = flush_cnt_q;
    seen_d      = seen_q;
    out_valid_d = out_valid_q && !out_ready_i;
    if (step) begin
      out_valid_d = 1'b1;
      seen_d      = (ctrl.clr ? 1'b0 : seen_q) | res.changed;
      if (accept && last_cell_i) begin
        flush_cnt_d = FCNT_W'(WIN);
      end else if (flushing) begin
        flush_cnt_d = flush_cnt_q - FCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      die_mask_q   <= '0;
      birth_mask_q <= '0;
      flush_cnt_q  <= '0;
      seen_q       <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      flush_cnt_q <= flush_cnt_d;
      seen_q      <= seen_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i) begin
        case (r4la_pkg::cfg_idx_e'(cfg_index_i))
          r4la_pkg::CFG_DIE_MASK:   die_mask_q   <= cfg_data_i;
          r4la_pkg::CFG_BIRTH_MASK: birth_mask_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (step) begin
      cell_out_q <= res.next;
      changed_q  <= res.changed;
      any_q      <= seen_d;
      end_q      <= end_now;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign cell_out_o     = cell_out_q;
  assign cell_changed_o = changed_q;
  assign any_change_o   = any_q;
  assign run_end_o      = end_q;

endmodule

`default_nettype wire

/* verif/r4la_step_checker.sv */
// Checker for the radius-4 line automaton step: predicts each cell result and compares it.
`timescale 1ns / 1ps

module r4la_step_checker #(
  parameter int unsigned RADIUS = r4la_pkg::DEF_RADIUS
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  input  logic                           cfg_ready_i,
  input  logic [r4la_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [r4la_pkg::MASK_BITS-1:0] cfg_data_i,
  input  logic                           in_valid_i,
  input  logic                           in_ready_i,
  input  logic                           cell_in_i,
  input  logic                           first_cell_i,
  input  logic                           last_cell_i,
  input  logic                           out_valid_i,
  input  logic                           out_ready_i,
  input  logic                           cell_out_i,
  input  logic                           cell_changed_i,
  input  logic                           any_change_i,
  input  logic                           run_end_i,
  output int                             err_count_o,
  output int                             outstanding_o,
  output int                             checked_o
);

  typedef struct packed {
    logic state;
    logic changed;
    logic any_seen;
    logic run_end;
  } gen_cell_t;

  logic [r4la_pkg::MASK_BITS-1:0] die_rule;
  logic [r4la_pkg::MASK_BITS-1:0] birth_rule;
  logic [2*RADIUS-1:0]            window;       // bit 0 newest
  logic                           seen_change;
  gen_cell_t                      pending_cells[$];
  int                             n_err     = 0;
  int                             n_pending = 0;
  int                             n_checked = 0;

  assign err_count_o   = n_err;
  assign outstanding_o = n_pending;
  assign checked_o     = n_checked;

  task automatic log_fault(input string msg);
    $display("[%0t] checker: %s", $time, msg);
    n_err++;
  endtask

  task automatic compare_field(input string field, input logic got, input logic want);
    if (got !== want)
      log_fault($sformatf("result %0d: %s is %b, expected %b", n_checked, field, got, want));
  endtask

  // shift one cell in and queue the new state of the window centre
  function automatic void advance_window(input logic c, input logic fin);
    logic [2*RADIUS:0] w;
    logic              centre;
    logic              nxt;
    int unsigned       k;
    gen_cell_t         r;
    w      = {window, c};
    centre = w[RADIUS];
    k      = $countones(w) - centre;
    if (centre) nxt = !((k < r4la_pkg::MASK_BITS) && die_rule[k]);
    else nxt = (k < r4la_pkg::MASK_BITS) && birth_rule[k];
    if (nxt != centre) seen_change = 1'b1;
    r.state    = nxt;
    r.changed  = (nxt != centre);
    r.any_seen = seen_change;
    r.run_end  = fin;
    pending_cells = {pending_cells, r};
    window = w[2*RADIUS-1:0];
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    gen_cell_t want;
    if (!rst_ni) begin
      die_rule    = '0;
      birth_rule  = '0;
      window      = '0;
      seen_change = 1'b0;
      pending_cells.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          r4la_pkg::CFG_DIE_MASK:   die_rule   = cfg_data_i;
          r4la_pkg::CFG_BIRTH_MASK: birth_rule = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        if (first_cell_i) begin
          window      = '0;
          seen_change = 1'b0;
        end
        advance_window(cell_in_i, 1'b0);
        if (last_cell_i)
          for (int j = 0; j < 2*RADIUS; j++) advance_window(1'b0, j == 2*RADIUS-1);
      end
      if (out_valid_i && out_ready_i) begin
        if (pending_cells.size() == 0) begin
          log_fault("result item arrived with nothing expected");
        end else begin
          want = pending_cells.pop_front();
          compare_field("cell_out", cell_out_i, want.state);
          compare_field("cell_changed", cell_changed_i, want.changed);
          compare_field("any_change", any_change_i, want.any_seen);
          compare_field("run_end", run_end_i, want.run_end);
          n_checked++;
        end
      end
    end
    n_pending = pending_cells.size();
  end

endmodule

/* verif/tb_radius4_line_automaton_step.sv */
// Testbench top for the radius-4 line automaton step: stimulus, rule settings and verdict.
`timescale 1ns / 1ps

module tb_radius4_line_automaton_step;

  localparam int unsigned RADIUS     = r4la_pkg::DEF_RADIUS;
  localparam int unsigned LONG_STALL = 80;

  logic                           clk_i = 1'b0;
  logic                           rst_ni;
  logic                           cfg_valid_i;
  logic                           cfg_ready_o;
  logic [r4la_pkg::CFG_IDX_W-1:0] cfg_index_i;
  logic [r4la_pkg::MASK_BITS-1:0] cfg_data_i;
  logic                           in_valid_i;
  logic                           in_ready_o;
  logic                           cell_in_i;
  logic                           first_cell_i;
  logic                           last_cell_i;
  logic                           out_valid_o;
  logic                           out_ready_i;
  logic                           cell_out_o;
  logic                           cell_changed_o;
  logic                           any_change_o;
  logic                           run_end_o;

  int err_count;
  int outstanding;
  int checked;
  int n_items;
  int n_gens;
  int n_settings;
  bit idle_on;
  bit stall_req;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  radius4_line_automaton_step #(.RADIUS(RADIUS)) DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .cell_in_i     (cell_in_i),
    .first_cell_i  (first_cell_i),
    .last_cell_i   (last_cell_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .cell_out_o    (cell_out_o),
    .cell_changed_o(cell_changed_o),
    .any_change_o  (any_change_o),
    .run_end_o     (run_end_o)
  );

  r4la_step_checker #(.RADIUS(RADIUS)) u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_i   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_ready_i    (in_ready_o),
    .cell_in_i     (cell_in_i),
    .first_cell_i  (first_cell_i),
    .last_cell_i   (last_cell_i),
    .out_valid_i   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .cell_out_i    (cell_out_o),
    .cell_changed_i(cell_changed_o),
    .any_change_i  (any_change_o),
    .run_end_i     (run_end_o),
    .err_count_o   (err_count),
    .outstanding_o (outstanding),
    .checked_o     (checked)
  );

  task automatic send_cell(input logic c, input logic f, input logic l);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    cell_in_i    <= c;
    first_cell_i <= f;
    last_cell_i  <= l;
    do @(posedge clk_i); while (!in_ready_o);
    n_items++;
  endtask

  // one generation; live_edges forces live cells under the first and last marks
  task automatic send_gen(input int len, input int alive_pct, input bit live_edges);
    logic c;
    for (int i = 0; i < len; i++) begin
      c = ($urandom_range(0, 99) < alive_pct);
      if (live_edges && (i == 0 || i == len - 1)) c = 1'b1;
      send_cell(c, i == 0, i == len - 1);
    end
    n_gens++;
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (outstanding != 0);
    repeat (2*RADIUS + 4) @(posedge clk_i);
  endtask

  task automatic set_rules(input logic [r4la_pkg::MASK_BITS-1:0] die,
                           input logic [r4la_pkg::MASK_BITS-1:0] birth);
    wait_idle();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= r4la_pkg::CFG_DIE_MASK;
    cfg_data_i  <= die;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_index_i <= r4la_pkg::CFG_BIRTH_MASK;
    cfg_data_i  <= birth;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    n_settings++;
  endtask

  function automatic logic [r4la_pkg::MASK_BITS-1:0] pick_mask();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      default: return r4la_pkg::MASK_BITS'($urandom);
    endcase
  endfunction

  // receiver side: short random stalls, plus one long hold-off on request
  initial begin
    out_ready_i <= 1'b0;
    @(posedge rst_ni);
    forever begin
      if (stall_req) begin
        out_ready_i <= 1'b0;
        repeat (LONG_STALL) @(posedge clk_i);
        stall_req = 1'b0;
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
      end
    end
  end

  initial begin
    int  choice;
    int  rounds;
    bit  stall_done;
    rst_ni       <= 1'b0;
    cfg_valid_i  <= 1'b0;
    cfg_index_i  <= r4la_pkg::CFG_DIE_MASK;
    cfg_data_i   <= '0;
    in_valid_i   <= 1'b0;
    cell_in_i    <= 1'b0;
    first_cell_i <= 1'b0;
    last_cell_i  <= 1'b0;
    idle_on      = 1'b1;
    stall_req    = 1'b0;
    stall_done   = 1'b0;
    rounds       = 0;
    n_items      = 0;
    n_gens       = 0;
    n_settings   = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // lone cell under reset rules: nothing may change
    send_cell(1'b1, 1'b1, 1'b1);
    set_rules('1, '1);
    send_cell(1'b1, 1'b1, 1'b1);
    send_cell(1'b0, 1'b1, 1'b1);
    // start without a first mark
    send_cell(1'b1, 1'b0, 1'b0);
    send_cell(1'b0, 1'b0, 1'b0);
    send_cell(1'b1, 1'b0, 1'b1);
    set_rules(9'b1_1110_0011, 9'b0_0011_1000);
    send_gen(9, 100, 1'b1);
    // first mark again in mid-run clears the window
    send_cell(1'b1, 1'b1, 1'b0);
    send_cell(1'b1, 1'b0, 1'b0);
    send_cell(1'b1, 1'b1, 1'b0);
    send_cell(1'b0, 1'b0, 1'b1);
    set_rules('0, '1);
    send_gen(6, 50, 1'b0);

    while (n_items < 480) begin
      if (n_items > 420) idle_on = 1'b0;
      if (rounds % 6 == 0) set_rules(pick_mask(), pick_mask());
      rounds++;
      if (!stall_done && n_items > 200) begin
        stall_done = 1'b1;
        stall_req  = 1'b1;
        send_gen(40, 50, 1'b1);
      end
      choice = $urandom_range(0, 9);
      if (choice == 0)
        send_cell(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)));
      else if (choice == 1)
        send_gen($urandom_range(1, 12), $urandom_range(0, 100), 1'b0);
      else if (choice == 2)
        send_gen($urandom_range(17, 48), $urandom_range(20, 80), 1'b1);
      else
        send_gen($urandom_range(1, 16), $urandom_range(0, 100), 1'b1);
    end

    wait_idle();
    $display("Ran %0d cell items in %0d generations under %0d rule settings; %0d results checked.",
             n_items, n_gens, n_settings, checked);
    $display("Covered lone cells, unmarked starts, repeated first marks and a long output stall.");
    if (err_count == 0 && outstanding == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("Timeout: run did not complete");
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
